### hdl/iee_pkg.sv
// shared constants, types and helpers of the infix expression evaluator
`default_nettype none
package iee_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_LPAR = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIVZERO  = 2'd1,
    ERR_SYNTAX   = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_t;

  function automatic logic [1:0] prec(input logic [2:0] op);
    logic [1:0] p;
    p = 2'd0;
    if (op == OP_MUL || op == OP_DIV) p = 2'd2;
    else if (op == OP_ADD || op == OP_SUB) p = 2'd1;
    return p;
  endfunction

endpackage
`default_nettype wire

### hdl/iee_ram.sv
// generic single write port ram with registered read
`default_nettype none
module iee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### hdl/iee_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none
module iee_div
  import iee_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [VALUE_WIDTH-1:0] divisor,
  output logic                        done,
  output logic      [VALUE_WIDTH-1:0] quotient
);
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0] den_r, den_nxt;
  logic                   neg_r, neg_nxt;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    trial    = {rem_r, quo_r[VALUE_WIDTH-1]};
    diff     = trial - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_WIDTH);
      rem_nxt  = '0;
      quo_nxt  = dividend[VALUE_WIDTH-1] ? (~dividend + 1'b1) : dividend;
      den_nxt  = divisor[VALUE_WIDTH-1] ? (~divisor + 1'b1) : divisor;
      neg_nxt  = dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
    end else if (busy_r) begin
      if (!diff[VALUE_WIDTH]) begin
        rem_nxt = diff[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VALUE_WIDTH-1:0];
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;
endmodule
`default_nettype wire

### hdl/infix_expression_evaluator.sv
// top level: shunting-yard sequencer over the operator and operand stack rams
//
// channel  direction  beat fields                      flow control
// in_      input      char_code[7:0], last_char        in_valid / in_stall
// out_     output     value[31:0] signed, error_code   out_valid / out_stall
//
// a digit or opening parenthesis is handled in S_IDLE; an operator or closing
// parenthesis passes S_TOP and S_TOPW (only S_TOP on an empty operator stack), then
// S_RR, S_RL, S_EXEC and S_WB for each operator it reduces; a division waits in S_DIV.
// a last character also passes S_FCHK, S_RES and S_EMIT after its final reductions.
// the result waits in the output register; the next character is taken meanwhile,
// but the next last character holds in S_EMIT while a stalled result is still waiting.
// reset is synchronous; stack rams need no clearing, only the depth counters.
`default_nettype none
module infix_expression_evaluator
  import iee_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_char_code,
  input  wire logic               in_last_char,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_value,
  output logic        [1:0]       out_error_code
);
  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_TOP  = 11'b00000000010,
    S_TOPW = 11'b00000000100,
    S_RR   = 11'b00000001000,
    S_RL   = 11'b00000010000,
    S_EXEC = 11'b00000100000,
    S_DIV  = 11'b00001000000,
    S_WB   = 11'b00010000000,
    S_FCHK = 11'b00100000000,
    S_RES  = 11'b01000000000,
    S_EMIT = 11'b10000000000
  } state_t;

  typedef enum logic [2:0] {
    M_CLOSE = 3'b001,
    M_OP    = 3'b010,
    M_FIN   = 3'b100
  } mode_t;

  state_t                 state_r, state_nxt;
  mode_t                  mode_r, mode_nxt;
  logic [DEPTH_W-1:0]     od_r, od_nxt;
  logic [DEPTH_W-1:0]     vd_r, vd_nxt;
  logic [1:0]             err_r, err_nxt;
  logic                   last_r, last_nxt;
  logic [2:0]             op_r, op_nxt;
  logic [2:0]             alu_op_r, alu_op_nxt;
  logic [VALUE_WIDTH-1:0] lhs_r, lhs_nxt;
  logic [VALUE_WIDTH-1:0] rhs_r, rhs_nxt;
  logic [VALUE_WIDTH-1:0] t_r, t_nxt;
  logic [VALUE_WIDTH-1:0] res_r, res_nxt;
  logic                   ov_r, ov_nxt;
  logic [31:0]            oval_r, oval_nxt;
  logic [1:0]             oerr_r, oerr_nxt;

  logic                   opm_we;
  logic [ADDR_W-1:0]      opm_wa, opm_ra;
  logic [2:0]             opm_wd, opm_rd;
  logic                   vm_we;
  logic [ADDR_W-1:0]      vm_wa, vm_ra;
  logic [VALUE_WIDTH-1:0] vm_wd, vm_rd;
  logic                   div_start, div_done;
  logic [VALUE_WIDTH-1:0] div_q;
  logic [2*VALUE_WIDTH-1:0] prod;
  logic signed [63:0]     res_ext;
  logic                   last_now;
  state_t                 done_state;
  logic [DEPTH_W-1:0]     od_m1, vd_m1, vd_m2;

  iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_op_ram (
    .clk(clk), .wr_en(opm_we), .wr_addr(opm_wa), .wr_data(opm_wd),
    .rd_addr(opm_ra), .rd_data(opm_rd)
  );

  iee_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_val_ram (
    .clk(clk), .wr_en(vm_we), .wr_addr(vm_wa), .wr_data(vm_wd),
    .rd_addr(vm_ra), .rd_data(vm_rd)
  );

  iee_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(lhs_r),
    .divisor(rhs_r), .done(div_done), .quotient(div_q)
  );

  assign prod    = lhs_r * rhs_r;
  assign res_ext = 64'(signed'(res_r));
  assign od_m1   = od_r - 1'b1;
  assign vd_m1   = vd_r - 1'b1;
  assign vd_m2   = vd_r - 2'd2;

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    od_nxt     = od_r;
    vd_nxt     = vd_r;
    err_nxt    = err_r;
    last_nxt   = last_r;
    op_nxt     = op_r;
    alu_op_nxt = alu_op_r;
    lhs_nxt    = lhs_r;
    rhs_nxt    = rhs_r;
    t_nxt      = t_r;
    res_nxt    = res_r;
    ov_nxt     = ov_r;
    oval_nxt   = oval_r;
    oerr_nxt   = oerr_r;
    opm_we     = 1'b0;
    opm_wa     = od_r[ADDR_W-1:0];
    opm_wd     = op_r;
    opm_ra     = od_m1[ADDR_W-1:0];
    vm_we      = 1'b0;
    vm_wa      = vd_r[ADDR_W-1:0];
    vm_wd      = t_r;
    vm_ra      = vd_m1[ADDR_W-1:0];
    div_start  = 1'b0;
    in_stall   = (state_r != S_IDLE);
    last_now   = (state_r == S_IDLE) ? in_last_char : last_r;
    done_state = last_now ? S_TOP : S_IDLE;

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last_char;
          mode_nxt = M_FIN;
          state_nxt = done_state;
          if (err_r == ERR_NONE) begin
            if (in_char_code >= CH_ZERO && in_char_code <= CH_NINE) begin
              if (vd_r == DEPTH_W'(STACK_DEPTH)) err_nxt = ERR_OVERFLOW;
              else begin
                vm_we  = 1'b1;
                vm_wd  = VALUE_WIDTH'(in_char_code - CH_ZERO);
                vd_nxt = vd_r + 1'b1;
              end
            end else if (in_char_code == CH_LPAR) begin
              if (od_r == DEPTH_W'(STACK_DEPTH)) err_nxt = ERR_OVERFLOW;
              else begin
                opm_we = 1'b1;
                opm_wd = OP_LPAR;
                od_nxt = od_r + 1'b1;
              end
            end else if (in_char_code == CH_RPAR) begin
              mode_nxt  = M_CLOSE;
              state_nxt = S_TOP;
            end else if (in_char_code == CH_PLUS || in_char_code == CH_MINUS ||
                         in_char_code == CH_STAR || in_char_code == CH_SLASH) begin
              mode_nxt  = M_OP;
              state_nxt = S_TOP;
              priority if (in_char_code == CH_PLUS)  op_nxt = OP_ADD;
              else if     (in_char_code == CH_MINUS) op_nxt = OP_SUB;
              else if     (in_char_code == CH_STAR)  op_nxt = OP_MUL;
              else                                   op_nxt = OP_DIV;
            end else begin
              err_nxt = ERR_SYNTAX;
            end
          end
        end
      end
      S_TOP: begin
        if (err_r != ERR_NONE || od_r == '0) begin
          unique case (mode_r)
            M_CLOSE: begin
              if (err_r == ERR_NONE) err_nxt = ERR_SYNTAX;
              mode_nxt  = M_FIN;
              state_nxt = done_state;
            end
            M_OP: begin
              if (err_r == ERR_NONE) begin
                opm_we = 1'b1;
                od_nxt = od_r + 1'b1;
              end
              mode_nxt  = M_FIN;
              state_nxt = done_state;
            end
            default: state_nxt = S_FCHK;
          endcase
        end else begin
          state_nxt = S_TOPW;
        end
      end
      S_TOPW: begin
        logic do_reduce;
        do_reduce = 1'b0;
        unique case (mode_r)
          M_CLOSE: begin
            if (opm_rd == OP_LPAR) begin
              od_nxt    = od_m1;
              mode_nxt  = M_FIN;
              state_nxt = done_state;
            end else do_reduce = 1'b1;
          end
          M_OP: begin
            if (opm_rd != OP_LPAR && prec(opm_rd) >= prec(op_r)) do_reduce = 1'b1;
            else begin
              if (od_r == DEPTH_W'(STACK_DEPTH)) err_nxt = ERR_OVERFLOW;
              else begin
                opm_we = 1'b1;
                od_nxt = od_r + 1'b1;
              end
              mode_nxt  = M_FIN;
              state_nxt = done_state;
            end
          end
          default: begin
            if (opm_rd == OP_LPAR) begin
              err_nxt   = ERR_SYNTAX;
              state_nxt = S_TOP;
            end else do_reduce = 1'b1;
          end
        endcase
        if (do_reduce) begin
          od_nxt     = od_m1;
          alu_op_nxt = opm_rd;
          if (vd_r < DEPTH_W'(2)) begin
            err_nxt   = ERR_SYNTAX;
            state_nxt = S_TOP;
          end else begin
            vm_ra     = vd_m1[ADDR_W-1:0];
            state_nxt = S_RR;
          end
        end
      end
      S_RR: begin
        rhs_nxt   = vm_rd;
        vm_ra     = vd_m2[ADDR_W-1:0];
        state_nxt = S_RL;
      end
      S_RL: begin
        lhs_nxt   = vm_rd;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_WB;
        unique case (alu_op_r)
          OP_ADD: t_nxt = lhs_r + rhs_r;
          OP_SUB: t_nxt = lhs_r - rhs_r;
          OP_MUL: t_nxt = prod[VALUE_WIDTH-1:0];
          OP_DIV: begin
            if (rhs_r == '0) begin
              err_nxt   = ERR_DIVZERO;
              state_nxt = S_TOP;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          default: begin
            err_nxt   = ERR_SYNTAX;
            state_nxt = S_TOP;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          t_nxt     = div_q;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        vm_we     = 1'b1;
        vm_wa     = vd_m2[ADDR_W-1:0];
        vd_nxt    = vd_m1;
        state_nxt = S_TOP;
      end
      S_FCHK: begin
        if (err_r == ERR_NONE && vd_r != DEPTH_W'(1)) err_nxt = ERR_SYNTAX;
        vm_ra     = '0;
        state_nxt = S_RES;
      end
      S_RES: begin
        res_nxt   = (err_r == ERR_NONE) ? vm_rd : '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          oval_nxt  = res_ext[31:0];
          oerr_nxt  = err_r;
          od_nxt    = '0;
          vd_nxt    = '0;
          err_nxt   = ERR_NONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_FIN;
      od_r    <= '0;
      vd_r    <= '0;
      err_r   <= ERR_NONE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      od_r    <= od_nxt;
      vd_r    <= vd_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
    last_r   <= last_nxt;
    op_r     <= op_nxt;
    alu_op_r <= alu_op_nxt;
    lhs_r    <= lhs_nxt;
    rhs_r    <= rhs_nxt;
    t_r      <= t_nxt;
    res_r    <= res_nxt;
    oval_r   <= oval_nxt;
    oerr_r   <= oerr_nxt;
  end

  assign out_valid      = ov_r;
  assign out_value      = oval_r;
  assign out_error_code = oerr_r;
endmodule
`default_nettype wire

### hdl/iee_check.sv
// port-level checker for the infix expression evaluator, bound to the top level
`default_nettype none
module iee_check
  import iee_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_value,
  input wire logic [1:0]  out_error_code
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_error_code))
    else $error("stalled result beat changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_value == '0)
    else $error("error result carries a nonzero value");

  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_value, out_error_code}))
    else $error("result beat carries unknown bits");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not quiet after reset");
endmodule

bind infix_expression_evaluator iee_check u_iee_check (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
  .out_error_code(out_error_code)
);
`default_nettype wire
